[sv/usw_pkg.sv]
// ============================================================================
// usw_pkg
// Shared types and constants for the up/down stopwatch timer.
// ============================================================================
package usw_pkg;

    // Time constants in milliseconds
    localparam logic [26:0] MAX_MS    = 27'd86399999;
    localparam logic [26:0] SECOND_MS = 27'd1000;
    localparam logic [16:0] SEC_PER_MIN = 17'd60;
    localparam logic [10:0] MIN_PER_HR  = 11'd60;

    // Reciprocals for exact constant division over the value ranges used here
    // floor(x / 1000) = (x * RECIP_1000) >> SHIFT_1000 for x < 2^27
    localparam logic [26:0] RECIP_1000 = 27'd68719477;
    localparam int          SHIFT_1000 = 36;
    // floor(x / 60) = (x * RECIP_60) >> SHIFT_60 for x < 86400
    localparam logic [17:0] RECIP_60   = 18'd139811;
    localparam int          SHIFT_60   = 23;

    // Result queue
    localparam int RES_DEPTH = 8;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    // Command queue
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);
    localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

    // Input op codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_TOGGLE = 3'd1;
    localparam logic [2:0] OP_DIR    = 3'd2;
    localparam logic [2:0] OP_RESET  = 3'd3;
    localparam logic [2:0] OP_LOAD   = 3'd4;

    typedef enum logic [2:0] {
        KIND_NOP    = 3'd0,
        KIND_TICK   = 3'd1,
        KIND_TOGGLE = 3'd2,
        KIND_DIR    = 3'd3,
        KIND_RESET  = 3'd4,
        KIND_LOAD   = 3'd5
    } kind_t;

    typedef struct packed {
        logic [2:0]  op;
        logic        direction_down;
        logic [26:0] load_ms;
    } in_t;

    typedef struct packed {
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [9:0]  millis;
        logic [26:0] total_ms;
        logic        running;
        logic        counting_down;
    } out_t;

    // Decoded command between front and back
    typedef struct packed {
        kind_t       kind;
        logic        dir;
        logic [26:0] load;
    } cmd_t;

    // State snapshot handed to the conversion pipeline
    typedef struct packed {
        logic        valid;
        logic [26:0] count;
        logic        running;
        logic        down;
    } snap_t;

endpackage

[sv/usw_front.sv]
// ============================================================================
// usw_front
// Accepts items, decodes the op and saturates the load value, and queues
// the decoded commands for the execution stage.
// ============================================================================
module usw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  usw_pkg::in_t      cmd,
    output logic              cmd_valid,
    output usw_pkg::cmd_t     cmd_head,
    input  logic              cmd_pop
);

    usw_pkg::cmd_t                    mem [usw_pkg::CMD_DEPTH];
    logic [usw_pkg::CMD_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [usw_pkg::CMD_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [usw_pkg::CMD_CW-1:0]       cnt_reg, cnt_next;
    usw_pkg::cmd_t                    dec;
    logic                             wr_en;
    logic                             rd_en;

    always_comb
    begin
        dec.dir  = cmd.direction_down;
        dec.load = (cmd.load_ms > usw_pkg::MAX_MS) ? usw_pkg::MAX_MS : cmd.load_ms;
        case (cmd.op)
            usw_pkg::OP_TICK:   dec.kind = usw_pkg::KIND_TICK;
            usw_pkg::OP_TOGGLE: dec.kind = usw_pkg::KIND_TOGGLE;
            usw_pkg::OP_DIR:    dec.kind = usw_pkg::KIND_DIR;
            usw_pkg::OP_RESET:  dec.kind = usw_pkg::KIND_RESET;
            usw_pkg::OP_LOAD:   dec.kind = usw_pkg::KIND_LOAD;
            default:            dec.kind = usw_pkg::KIND_NOP;
        endcase
    end

    assign full      = (cnt_reg == usw_pkg::CMD_CW'(usw_pkg::CMD_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd_head  = mem[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= dec;
        end
    end

endmodule

[sv/usw_exec.sv]
// ============================================================================
// usw_exec
// Timer state: while a result slot is free, applies one queued command per
// cycle, snapshots the new state and reserves a result queue slot for it.
// ============================================================================
module usw_exec (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  usw_pkg::cmd_t               cmd_head,
    output logic                        cmd_pop,
    input  logic                        res_taken,
    output logic [usw_pkg::RES_CW-1:0]  reserved,
    output usw_pkg::snap_t              snap
);

    logic [26:0]                 count_reg, count_next;
    logic [26:0]                 preset_reg, preset_next;
    logic                        running_reg, running_next;
    logic                        down_reg, down_next;
    logic [usw_pkg::RES_CW-1:0]  reserved_reg, reserved_next;
    usw_pkg::snap_t              snap_reg, snap_next;

    // A slot is free when items in flight plus queued results leave room
    assign cmd_pop = cmd_valid && (reserved_reg < usw_pkg::RES_CW'(usw_pkg::RES_DEPTH));

    always_comb
    begin
        count_next   = count_reg;
        preset_next  = preset_reg;
        running_next = running_reg;
        down_next    = down_reg;
        if (cmd_pop)
        begin
            case (cmd_head.kind)
                usw_pkg::KIND_TICK:
                begin
                    if (running_reg)
                    begin
                        if (down_reg)
                        begin
                            if (count_reg <= 27'd1)
                            begin
                                // countdown expired: flip to counting up from zero
                                count_next = '0;
                                down_next  = 1'b0;
                            end
                            else
                            begin
                                count_next = count_reg - 27'd1;
                            end
                        end
                        else if (count_reg >= usw_pkg::MAX_MS)
                        begin
                            count_next = '0;
                        end
                        else
                        begin
                            count_next = count_reg + 27'd1;
                        end
                    end
                end
                usw_pkg::KIND_TOGGLE: running_next = !running_reg;
                usw_pkg::KIND_DIR:    down_next    = cmd_head.dir;
                usw_pkg::KIND_RESET:
                begin
                    running_next = 1'b0;
                    count_next   = down_reg ? preset_reg : '0;
                end
                usw_pkg::KIND_LOAD:
                begin
                    count_next  = cmd_head.load;
                    preset_next = cmd_head.load;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        snap_next.valid   = cmd_pop;
        snap_next.count   = count_next;
        snap_next.running = running_next;
        snap_next.down    = down_next;
    end

    always_comb
    begin
        reserved_next = reserved_reg;
        if (cmd_pop && !res_taken)
        begin
            reserved_next = reserved_reg + 1'b1;
        end
        else if (!cmd_pop && res_taken)
        begin
            reserved_next = reserved_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            preset_reg   <= '0;
            running_reg  <= 1'b0;
            down_reg     <= 1'b0;
            reserved_reg <= '0;
            snap_reg     <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            preset_reg   <= preset_next;
            running_reg  <= running_next;
            down_reg     <= down_next;
            reserved_reg <= reserved_next;
            snap_reg     <= snap_next;
        end
    end

    assign reserved = reserved_reg;
    assign snap     = snap_reg;

endmodule

[sv/usw_conv.sv]
// ============================================================================
// usw_conv
// Four-stage pipeline splitting a millisecond count into hours, minutes,
// seconds and milliseconds with reciprocal multiplies. Never stalls.
// ============================================================================
module usw_conv (
    input  logic             clk,
    input  logic             rst_n,
    input  usw_pkg::snap_t   snap,
    output logic             res_valid,
    output usw_pkg::out_t    res
);

    // stage 1: count * 1/1000
    logic        s1_valid_reg;
    usw_pkg::snap_t s1_snap_reg;
    logic [53:0] s1_prod_reg;

    // stage 2: whole seconds, millis, seconds * 1/60
    logic        s2_valid_reg;
    usw_pkg::snap_t s2_snap_reg;
    logic [16:0] s2_sec_reg;
    logic [9:0]  s2_ms_reg;
    logic [34:0] s2_prod_reg;

    // stage 3: whole minutes, seconds field, minutes * 1/60
    logic        s3_valid_reg;
    usw_pkg::snap_t s3_snap_reg;
    logic [10:0] s3_min_reg;
    logic [5:0]  s3_secs_reg;
    logic [9:0]  s3_ms_reg;
    logic [28:0] s3_prod_reg;

    // stage 4: result
    logic        s4_valid_reg;
    usw_pkg::out_t s4_res_reg;

    logic [16:0] sec_total;
    logic [10:0] min_total;
    logic [4:0]  hr_total;

    assign sec_total = s1_prod_reg[usw_pkg::SHIFT_1000 +: 17];
    assign min_total = s2_prod_reg[usw_pkg::SHIFT_60 +: 11];
    assign hr_total  = s3_prod_reg[usw_pkg::SHIFT_60 +: 5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= snap.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_snap_reg <= snap;
        s1_prod_reg <= 54'(snap.count) * 54'(usw_pkg::RECIP_1000);

        s2_snap_reg <= s1_snap_reg;
        s2_sec_reg  <= sec_total;
        s2_ms_reg   <= 10'(s1_snap_reg.count - 27'(sec_total) * usw_pkg::SECOND_MS);
        s2_prod_reg <= 35'(sec_total) * 35'(usw_pkg::RECIP_60);

        s3_snap_reg <= s2_snap_reg;
        s3_min_reg  <= min_total;
        s3_secs_reg <= 6'(s2_sec_reg - 17'(min_total) * usw_pkg::SEC_PER_MIN);
        s3_ms_reg   <= s2_ms_reg;
        s3_prod_reg <= 29'(min_total) * 29'(usw_pkg::RECIP_60);

        // count never reaches one day, so whole hours are already below 24
        s4_res_reg.hours         <= hr_total;
        s4_res_reg.minutes       <= 6'(s3_min_reg - 11'(hr_total) * usw_pkg::MIN_PER_HR);
        s4_res_reg.seconds       <= s3_secs_reg;
        s4_res_reg.millis        <= s3_ms_reg;
        s4_res_reg.total_ms      <= s3_snap_reg.count;
        s4_res_reg.running       <= s3_snap_reg.running;
        s4_res_reg.counting_down <= s3_snap_reg.down;
    end

    assign res_valid = s4_valid_reg;
    assign res       = s4_res_reg;

endmodule

[sv/usw_res_fifo.sv]
// ============================================================================
// usw_res_fifo
// Result queue. Writes are never refused: the execution stage only issues
// an item when a slot is reserved for it.
// ============================================================================
module usw_res_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr,
    input  usw_pkg::out_t               wr_data,
    output logic                        empty,
    input  logic                        pop,
    output usw_pkg::out_t               result,
    output logic [usw_pkg::RES_CW-1:0]  level
);

    usw_pkg::out_t                 mem [usw_pkg::RES_DEPTH];
    logic [usw_pkg::RES_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [usw_pkg::RES_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [usw_pkg::RES_CW-1:0]    cnt_reg, cnt_next;
    logic                          rd_en;

    assign empty  = (cnt_reg == '0);
    assign rd_en  = pop && !empty;
    assign result = mem[rd_ptr_reg];
    assign level  = cnt_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr && rd_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[sv/updown_stopwatch_timer.sv]
// ============================================================================
// updown_stopwatch_timer
// Millisecond stopwatch / countdown timer with queue-style ports.
// ============================================================================
// Each item is one operation (tick, run toggle, direction, reset, load) and
// yields exactly one result: the count after the operation as hours, minutes,
// seconds, milliseconds and total, plus the run and direction flags. The
// block sustains one item per clock in both directions while results are
// popped. A pushed item passes through the 4-entry command queue, the state
// update register and the conversion pipeline (its reciprocal multiplies set
// the depth), then the 8-entry result queue. Full rises only once the command
// queue backs up, which happens when results are not popped and all eight
// result slots are taken.
module updown_stopwatch_timer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  usw_pkg::in_t   cmd,
    output logic           empty,
    input  logic           pop,
    output usw_pkg::out_t  result
);

    logic                        cmd_valid;
    usw_pkg::cmd_t               cmd_head;
    logic                        cmd_pop;
    logic [usw_pkg::RES_CW-1:0]  reserved;
    logic [usw_pkg::RES_CW-1:0]  level;
    usw_pkg::snap_t              snap;
    logic                        res_valid;
    usw_pkg::out_t               res;
    logic                        res_taken;

    assign res_taken = pop && !empty;

    usw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop)
    );

    usw_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_taken (res_taken),
        .reserved  (reserved),
        .snap      (snap)
    );

    usw_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .snap      (snap),
        .res_valid (res_valid),
        .res       (res)
    );

    usw_res_fifo u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_valid),
        .wr_data (res),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .level   (level)
    );

    // queued results never exceed the slots reserved for them
    a_reserve_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
        level <= reserved)
        else $error("result queue holds more items than reserved");

    // no reservation outstanding means nothing queued
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (reserved == '0) |-> empty)
        else $error("result present with no reservation");

    // a conversion result is always preceded by an executed command
    a_conv_latency: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(cmd_pop, 5))
        else $error("conversion result without matching command");

    // the timer never issues past the result queue capacity
    a_no_overissue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (reserved < usw_pkg::RES_CW'(usw_pkg::RES_DEPTH)))
        else $error("command executed without a free result slot");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking testbench for the up/down stopwatch timer.
// ============================================================================
// A short table of hand-picked operations (stopped ticks, spare op codes,
// saturating loads, day wrap, countdown expiry, reset to preset) runs first.
// Random operation streams follow under several idle and stall patterns,
// including one long receiver hold that backs the block up into full.
// Every result is compared with a predictor of the timer or with the table's expected reading.
module tb_top;

    localparam int          CLK_HALF_NS      = 4;
    localparam int          RESET_CYCLES     = 8;
    localparam int          DRAIN_CYCLES     = 12;
    localparam int          LONG_HOLD_CYCLES = 64;
    localparam int          ITEMS_PER_PHASE  = 196;
    localparam int          PRESSURE_ITEMS   = 40;
    localparam int          MAX_REPORTS      = 10;
    localparam longint      TIMEOUT_NS       = 64'd1600000;
    localparam int unsigned DAY_MS           = 32'd86400000;
    localparam int unsigned HOUR_MS          = 32'd3600000;
    localparam int unsigned MINUTE_MS        = 32'd60000;
    localparam logic [2:0]  OP_SPARE_LO      = 3'd5;
    localparam logic [2:0]  OP_SPARE_MID     = 3'd6;
    localparam logic [2:0]  OP_SPARE_HI      = 3'd7;

    typedef struct {
        usw_pkg::in_t  item;
        bit            typed;
        usw_pkg::out_t want;
    } step_row_t;

    logic          clk;
    logic          rst_n;
    logic          push;
    logic          full;
    usw_pkg::in_t  cmd;
    logic          empty;
    logic          pop = 1'b0;
    usw_pkg::out_t result;

    // Predictor state
    logic [26:0] watch_ms;
    logic [26:0] watch_preset;
    logic        watch_run;
    logic        watch_down;

    usw_pkg::out_t expected_readings[$];
    step_row_t     directed_steps[$];

    int mismatches;
    int items_sent;
    int readings_checked;
    int full_stalls;
    int countdown_expiries;
    int day_wraps;
    int send_idle_pct;
    int recv_stall_pct;
    bit long_hold_req;
    bit long_hold_done;
    int hold_left;

    updown_stopwatch_timer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .cmd    (cmd),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial clk = 1'b0;
    always #(CLK_HALF_NS) clk = ~clk;

    // Applies one operation to the predictor and returns the reading after it
    function automatic usw_pkg::out_t advance_watch(input usw_pkg::in_t item);
        logic [26:0]   ld;
        int unsigned   c;
        usw_pkg::out_t r;
        case (item.op)
            usw_pkg::OP_TICK:
            begin
                if (watch_run)
                begin
                    if (watch_down)
                    begin
                        if (watch_ms <= 27'd1)
                        begin
                            watch_ms   = '0;
                            watch_down = 1'b0;
                            countdown_expiries++;
                        end
                        else
                        begin
                            watch_ms = watch_ms - 27'd1;
                        end
                    end
                    else if (32'(watch_ms) + 1 >= DAY_MS)
                    begin
                        watch_ms = '0;
                        day_wraps++;
                    end
                    else
                    begin
                        watch_ms = watch_ms + 27'd1;
                    end
                end
            end
            usw_pkg::OP_TOGGLE: watch_run = ~watch_run;
            usw_pkg::OP_DIR:    watch_down = item.direction_down;
            usw_pkg::OP_RESET:
            begin
                watch_run = 1'b0;
                watch_ms  = watch_down ? watch_preset : '0;
            end
            usw_pkg::OP_LOAD:
            begin
                ld = (item.load_ms > usw_pkg::MAX_MS) ? usw_pkg::MAX_MS : item.load_ms;
                watch_ms     = ld;
                watch_preset = ld;
            end
            default: ;
        endcase
        c = 32'(watch_ms);
        r.hours         = 5'((c / HOUR_MS) % 24);
        r.minutes       = 6'((c / MINUTE_MS) % 60);
        r.seconds       = 6'((c / 32'(usw_pkg::SECOND_MS)) % 60);
        r.millis        = 10'(c % 32'(usw_pkg::SECOND_MS));
        r.total_ms      = watch_ms;
        r.running       = watch_run;
        r.counting_down = watch_down;
        return r;
    endfunction

    function automatic usw_pkg::in_t random_item();
        usw_pkg::in_t it;
        int unsigned  pick;
        it.direction_down = 1'($urandom_range(1));
        it.load_ms        = 27'($urandom);
        pick = $urandom_range(99);
        if (pick < 55)
            it.op = usw_pkg::OP_TICK;
        else if (pick < 63)
            it.op = usw_pkg::OP_TOGGLE;
        else if (pick < 73)
            it.op = usw_pkg::OP_DIR;
        else if (pick < 80)
            it.op = usw_pkg::OP_RESET;
        else if (pick < 95)
        begin
            it.op = usw_pkg::OP_LOAD;
            // bias loads toward counts that expire or wrap within a few ticks
            case ($urandom_range(3))
                0:       it.load_ms = 27'($urandom_range(4));
                1:       it.load_ms = usw_pkg::MAX_MS - 27'($urandom_range(8));
                2:       it.load_ms = 27'($urandom_range(32'h7FFFFFF, DAY_MS));
                default: ;
            endcase
        end
        else
        begin
            it.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        end
        return it;
    endfunction

    task automatic add_row(input logic [2:0] op, input logic dir, input logic [26:0] ld,
                           input bit typed, input usw_pkg::out_t want);
        step_row_t row;
        row.item  = '{op: op, direction_down: dir, load_ms: ld};
        row.typed = typed;
        row.want  = want;
        directed_steps.push_back(row);
    endtask

    task automatic send_item(input usw_pkg::in_t item, input bit typed,
                             input usw_pkg::out_t want);
        usw_pkg::out_t reading;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        cmd  <= item;
        push <= 1'b1;
        @(posedge clk);
        while (full)
        begin
            full_stalls++;
            @(posedge clk);
        end
        reading = advance_watch(item);
        expected_readings.push_back(typed ? want : reading);
        items_sent++;
    endtask

    task automatic check_reading(input usw_pkg::out_t got);
        usw_pkg::out_t want;
        if (expected_readings.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("ERROR: unexpected item total_ms=%0d", got.total_ms);
            return;
        end
        want = expected_readings.pop_front();
        readings_checked++;
        if (got.hours !== want.hours || got.minutes !== want.minutes ||
            got.seconds !== want.seconds || got.millis !== want.millis ||
            got.total_ms !== want.total_ms || got.running !== want.running ||
            got.counting_down !== want.counting_down)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display({"ERROR: item %0d exp %0d:%0d:%0d.%0d tot=%0d run=%0d dn=%0d,",
                          " got %0d:%0d:%0d.%0d tot=%0d run=%0d dn=%0d"},
                         readings_checked, want.hours, want.minutes, want.seconds,
                         want.millis, want.total_ms, want.running, want.counting_down,
                         got.hours, got.minutes, got.seconds, got.millis, got.total_ms,
                         got.running, got.counting_down);
        end
    endtask

    // Result side: checks each popped item, stalls at random, one long hold
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            check_reading(result);
        if (long_hold_req && !long_hold_done)
        begin
            hold_left      = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        usw_pkg::out_t zero_reading;
        usw_pkg::out_t max_reading;
        usw_pkg::out_t wrap_reading;
        usw_pkg::out_t none;
        int            phase_send[4];
        int            phase_recv[4];

        rst_n          = 1'b0;
        push           = 1'b0;
        cmd            = '0;
        watch_ms       = '0;
        watch_preset   = '0;
        watch_run      = 1'b0;
        watch_down     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_req  = 1'b0;

        zero_reading = '0;
        none         = '0;
        max_reading  = '{hours: 5'd23, minutes: 6'd59, seconds: 6'd59, millis: 10'd999,
                         total_ms: usw_pkg::MAX_MS, running: 1'b0, counting_down: 1'b0};
        wrap_reading = zero_reading;
        wrap_reading.running = 1'b1;

        add_row(usw_pkg::OP_TICK,   1'b1, 27'h7FFFFFF,    1'b1, zero_reading);
        add_row(OP_SPARE_LO,        1'b1, 27'h7FFFFFF,    1'b1, zero_reading);
        add_row(OP_SPARE_HI,        1'b0, 27'h0000000,    1'b1, zero_reading);
        add_row(usw_pkg::OP_LOAD,   1'b0, 27'h7FFFFFF,    1'b1, max_reading);
        add_row(usw_pkg::OP_TOGGLE, 1'b0, 27'd0,          1'b0, none);
        add_row(usw_pkg::OP_TICK,   1'b0, 27'd0,          1'b1, wrap_reading);
        add_row(usw_pkg::OP_TICK,   1'b1, 27'd5,          1'b0, none);
        add_row(usw_pkg::OP_DIR,    1'b1, 27'd0,          1'b0, none);
        add_row(usw_pkg::OP_TICK,   1'b1, 27'd0,          1'b1, wrap_reading);
        add_row(usw_pkg::OP_DIR,    1'b1, 27'd0,          1'b0, none);
        add_row(usw_pkg::OP_TICK,   1'b0, 27'd0,          1'b1, wrap_reading);
        add_row(usw_pkg::OP_LOAD,   1'b1, 27'd2,          1'b0, none);
        add_row(usw_pkg::OP_DIR,    1'b1, 27'h7FFFFFF,    1'b0, none);
        add_row(usw_pkg::OP_TICK,   1'b0, 27'd0,          1'b0, none);
        add_row(usw_pkg::OP_RESET,  1'b0, 27'd0,          1'b0, none);
        add_row(usw_pkg::OP_TICK,   1'b1, 27'd0,          1'b0, none);
        add_row(usw_pkg::OP_DIR,    1'b0, 27'd0,          1'b0, none);
        add_row(usw_pkg::OP_RESET,  1'b1, 27'd0,          1'b1, zero_reading);
        add_row(usw_pkg::OP_LOAD,   1'b0, usw_pkg::MAX_MS, 1'b1, max_reading);
        add_row(usw_pkg::OP_LOAD,   1'b0, 27'(DAY_MS),    1'b1, max_reading);
        add_row(usw_pkg::OP_LOAD,   1'b1, 27'd3723456,    1'b0, none);
        add_row(OP_SPARE_MID,       1'b1, 27'd1,          1'b0, none);
        add_row(usw_pkg::OP_TOGGLE, 1'b1, 27'd0,          1'b0, none);
        add_row(usw_pkg::OP_DIR,    1'b1, 27'd0,          1'b0, none);
        add_row(usw_pkg::OP_TICK,   1'b0, 27'd0,          1'b0, none);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
            send_item(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].want);

        // Back-pressure: receiver holds off while items keep coming
        long_hold_req <= 1'b1;
        repeat (PRESSURE_ITEMS) send_item(random_item(), 1'b0, none);

        phase_send = '{0, 58, 0, 32};
        phase_recv = '{0, 0, 58, 32};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = phase_send[p];
            recv_stall_pct <= phase_recv[p];
            repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, none);
        end
        push <= 1'b0;

        while (expected_readings.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d operations, %0d items checked, %0d mismatches.",
                 items_sent, readings_checked, mismatches);
        $display("Saw %0d countdown expiries, %0d day wraps, %0d cycles with input full.",
                 countdown_expiries, day_wraps, full_stalls);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
